@@ sv/ust_pkg.sv @@
package ust_pkg;

   localparam int CAPACITY   = 64;
   localparam int ELEM_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int COUNT_OUT_W = 7;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2
   } ust_op_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic rd_last;
      logic wr_remove;
      logic wr_add;
      logic set_ok;
      logic set_full;
   } ust_cmd_type;

   typedef struct packed {
      logic       hit;
      logic       scan_end;
      logic       full;
      logic [1:0] op;
   } ust_stat_type;

endpackage

@@ sv/ust_ctrl.sv @@
module ust_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic [1:0]            req_op,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ust_pkg::ust_stat_type stat,
   output ust_pkg::ust_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST_RD,
      ST_LAST_WR,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_op == ust_pkg::OP_ADD || req_op == ust_pkg::OP_REMOVE ||
                   req_op == ust_pkg::OP_SEARCH) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               case (stat.op)
                  ust_pkg::OP_REMOVE: state_in = ST_LAST_RD;
                  ust_pkg::OP_SEARCH: begin
                     cmd.set_ok = 1'b1;
                     state_in   = ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end else if (stat.scan_end) begin
               if (stat.op == ust_pkg::OP_ADD) begin
                  if (stat.full) begin
                     cmd.set_full = 1'b1;
                  end else begin
                     cmd.wr_add = 1'b1;
                     cmd.set_ok = 1'b1;
                  end
               end
               state_in = ST_RESP;
            end
         end
         ST_LAST_RD: begin
            cmd.rd_last = 1'b1;
            state_in    = ST_LAST_WR;
         end
         ST_LAST_WR: begin
            cmd.wr_remove = 1'b1;
            cmd.set_ok    = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

@@ sv/ust_datapath.sv @@
module ust_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_op,
   input  logic [ust_pkg::ELEM_WIDTH-1:0]      req_value,
   input  ust_pkg::ust_cmd_type                cmd,
   output ust_pkg::ust_stat_type               stat,
   output logic                                ok,
   output logic                                rejected_full,
   output logic [ust_pkg::CNT_W-1:0]           count
);

   logic [ust_pkg::ELEM_WIDTH-1:0] mem [ust_pkg::CAPACITY];

   logic [1:0]                     op_ff;
   logic [ust_pkg::ELEM_WIDTH-1:0] value_ff;
   logic [ust_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [ust_pkg::CNT_W-1:0]      idx_ff, idx_in;
   logic                           pend_ff, pend_in;
   logic [ust_pkg::ADDR_W-1:0]     pend_idx_ff;
   logic [ust_pkg::ADDR_W-1:0]     slot_ff;
   logic [ust_pkg::ELEM_WIDTH-1:0] rd_data_ff;
   logic                           ok_ff, full_ff;

   logic                           more;
   logic                           rd_en;
   logic [ust_pkg::ADDR_W-1:0]     rd_addr;
   logic [ust_pkg::CNT_W-1:0]      last_idx;
   logic                           wr_en;
   logic [ust_pkg::ADDR_W-1:0]     wr_addr;
   logic [ust_pkg::ELEM_WIDTH-1:0] wr_data;

   assign more     = (idx_ff < count_ff);
   assign last_idx = count_ff - 1'b1;

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = idx_ff[ust_pkg::ADDR_W-1:0];
      pend_in = 1'b0;
      idx_in  = idx_ff;
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.scan && more) begin
         rd_en   = 1'b1;
         pend_in = 1'b1;
         idx_in  = idx_ff + 1'b1;
      end else if (cmd.rd_last) begin
         rd_en   = 1'b1;
         rd_addr = last_idx[ust_pkg::ADDR_W-1:0];
      end
   end

   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = count_ff[ust_pkg::ADDR_W-1:0];
      wr_data  = value_ff;
      count_in = count_ff;
      if (cmd.wr_add) begin
         wr_en    = 1'b1;
         count_in = count_ff + 1'b1;
      end else if (cmd.wr_remove) begin
         wr_en    = 1'b1;
         wr_addr  = slot_ff;
         wr_data  = rd_data_ff;
         count_in = last_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
         pend_ff  <= 1'b0;
         ok_ff    <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pend_ff  <= pend_in;
         if (cmd.load) begin
            ok_ff   <= 1'b0;
            full_ff <= 1'b0;
         end else begin
            if (cmd.set_ok) begin
               ok_ff <= 1'b1;
            end
            if (cmd.set_full) begin
               full_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         value_ff <= req_value;
      end
      pend_idx_ff <= idx_ff[ust_pkg::ADDR_W-1:0];
      if (cmd.scan && stat.hit) begin
         slot_ff <= pend_idx_ff;
      end
   end

   assign stat.hit      = pend_ff && (rd_data_ff == value_ff);
   assign stat.scan_end = !pend_ff && !more;
   assign stat.full     = (count_ff == ust_pkg::CNT_W'(ust_pkg::CAPACITY));
   assign stat.op       = op_ff;

   assign ok            = ok_ff;
   assign rejected_full = full_ff;
   assign count         = count_ff;

endmodule

@@ sv/unordered_set_table.sv @@
// An unused command goes straight to a result; every other command first scans the store
// through its single read port at one entry per cycle, stopping at a match, and a remove then
// reads the last entry and writes it into the freed slot before the result is valid.
// Throughput: one item at a time; the next item is taken once the result is delivered.
// Reset (synchronous, active high) empties the set and idles the control; the store
// contents are not cleared and need no clearing pass.
module unordered_set_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] element
   input  logic [1:0]  req_tuser,  // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [6:0] count, [7] zero
   output logic [2:0]  rsp_tuser   // [0] ok, [1] is_empty, [2] rejected_full
);

   ust_pkg::ust_cmd_type         cmd;
   ust_pkg::ust_stat_type        stat;
   logic                         ok;
   logic                         rejected_full;
   logic [ust_pkg::CNT_W-1:0]    count;

   ust_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ust_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_tuser),
      .req_value     ((ust_pkg::ELEM_WIDTH)'(req_tdata)),
      .cmd           (cmd),
      .stat          (stat),
      .ok            (ok),
      .rejected_full (rejected_full),
      .count         (count)
   );

   assign rsp_tdata = {1'b0, (ust_pkg::COUNT_OUT_W)'(count)};
   assign rsp_tuser = {rejected_full, (count == '0), ok};

endmodule

@@ sv/ust_checker.sv @@
module ust_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result changed while stalled.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("Input taken while a result is pending.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[1] == (rsp_tdata[6:0] == 7'd0)))
      else $error("Empty flag disagrees with count.");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |->
         !rsp_tuser[0] && (rsp_tdata[6:0] == (ust_pkg::COUNT_OUT_W)'(ust_pkg::CAPACITY)))
      else $error("Refused add without a full store.");

endmodule

bind unordered_set_table ust_checker u_ust_checker (.*);
